// ===== src/lj_pair_force_accumulator_core_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the pair force accumulator
// Clocked assertion helpers for the module that carries checks.
// ----------------------------------------------------------------------------
`ifndef LJ_PAIR_FORCE_ACCUMULATOR_CORE_ASSERT_SVH
`define LJ_PAIR_FORCE_ACCUMULATOR_CORE_ASSERT_SVH

// Checked only outside reset.
`define LJPF_ASSERT_CLK(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("ljpf assertion failed");

// Checked at every edge, reset included.
`define LJPF_ASSERT_ALL(lbl, prop) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error("ljpf assertion failed");

`endif

// ===== src/ljpf_pkg.sv =====
// ----------------------------------------------------------------------------
// Pair force accumulator package
// Shared constants, the queued pair type and the periodic image function.
// ----------------------------------------------------------------------------
package ljpf_pkg;

  localparam int FracBitsDef  = 16;
  localparam int SumWidthDef  = 40;
  localparam int CfgWidth     = 31;
  localparam int CoordWidth   = 32;
  localparam int FifoDepth    = 2;

  localparam logic [CfgWidth-1:0] BoxReset = 31'd6658458;
  localparam logic [CfgWidth-1:0] CutReset = 31'd183914;
  localparam logic [CfgWidth-1:0] MinReset = 31'd72370;

  localparam logic [1:0] RegBox = 2'd0;
  localparam logic [1:0] RegCut = 2'd1;
  localparam logic [1:0] RegMin = 2'd2;

  localparam logic [63:0] SatMax  = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] GainLim = 64'h0AAA_AAAA_AAAA_AAAA;

  // One classified pair: image magnitudes, image signs and flags.
  typedef struct packed {
    logic [2:0][31:0] mag;
    logic [2:0]       pos;
    logic             skip;
    logic             last;
  } pair_t;

  function automatic logic [33:0] mag34(input logic signed [33:0] v);
    mag34 = v[33] ? 34'(-v) : 34'(v);
  endfunction

  function automatic logic signed [33:0] nearest_image(input logic signed [32:0] d,
                                                       input logic [CfgWidth-1:0] len);
    logic signed [33:0] dz;
    logic signed [33:0] dm;
    logic signed [33:0] dp;
    logic signed [33:0] best;
    dz = 34'(d);
    dm = dz - $signed({3'b000, len});
    dp = dz + $signed({3'b000, len});
    best = dm;
    if (mag34(dz) < mag34(best)) best = dz;
    if (mag34(dp) < mag34(best)) best = dp;
    nearest_image = best;
  endfunction

endpackage

// ===== src/lj_pair_force_accumulator_core.sv =====
// ----------------------------------------------------------------------------
// Lennard-Jones pair force accumulator
// Sums the pair accelerations of one particle over its partners.
// ----------------------------------------------------------------------------
// The slave stream carries one pair per transaction: both positions in tdata
// and the last-partner mark in tlast. On the last pair the master stream
// carries the x, y and z sums in tdata and the sticky saturation flag in
// tuser, after which the sums are cleared.
// Registers box_length, cutoff_distance and min_distance lie at byte
// addresses 0, 4 and 8 of the APB port. They are to be written only while
// the block idles; the block itself does not enforce this. A pair enters a
// two-entry queue in the cycle it arrives; the sequencer then takes a pair in
// range through the bit-serial reciprocal and the shared 32 by 32 multiplier,
// and skips the reciprocal for a pair outside the range window.
// A result is registered once its last pair finishes and stays until taken;
// while it waits the next pairs are still processed, and only a further last
// pair holds the sequencer. Reset clears the sums, the queue and the output
// and restores the register defaults.
module lj_pair_force_accumulator_core #(
  parameter int FRAC_BITS = ljpf_pkg::FracBitsDef,
  parameter int SUM_WIDTH = ljpf_pkg::SumWidthDef
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // self_x, self_y, self_z, other_x, other_y, other_z
  input  logic [191:0] s_axis_tdata,
  input  logic         s_axis_tlast,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // accel_x, accel_y, accel_z, zero padding
  output logic [((3*SUM_WIDTH+7)/8)*8-1:0] m_axis_tdata,
  // saturated
  output logic         m_axis_tuser,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [3:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);
  import ljpf_pkg::*;

  localparam int OutDataW = ((3 * SUM_WIDTH + 7) / 8) * 8;

  logic [CfgWidth-1:0] box_q, box_d, cut_q, cut_d, min_q, min_d;
  logic                cfg_wr;
  pair_t               pair_in, pair_out;
  logic [1:0]          fifo_cnt;
  logic                push, pop;
  logic [SUM_WIDTH-1:0] accel_x, accel_y, accel_z;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_comb begin
    box_d = box_q;
    cut_d = cut_q;
    min_d = min_q;
    if (cfg_wr) begin
      case (paddr[3:2])
        RegBox:  box_d = pwdata[CfgWidth-1:0];
        RegCut:  cut_d = pwdata[CfgWidth-1:0];
        RegMin:  min_d = pwdata[CfgWidth-1:0];
        default: box_d = box_q;
      endcase
    end
    case (paddr[3:2])
      RegBox:  prdata = {1'b0, box_q};
      RegCut:  prdata = {1'b0, cut_q};
      RegMin:  prdata = {1'b0, min_q};
      default: prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      box_q <= BoxReset;
      cut_q <= CutReset;
      min_q <= MinReset;
    end else begin
      box_q <= box_d;
      cut_q <= cut_d;
      min_q <= min_d;
    end
  end

  assign s_axis_tready = fifo_cnt != 2'(FifoDepth);
  assign push          = s_axis_tvalid && s_axis_tready;

  ljpf_front u_front (
    .pos_i  (s_axis_tdata),
    .last_i (s_axis_tlast),
    .box_i  (box_q),
    .cut_i  (cut_q),
    .pair_o (pair_in)
  );

  ljpf_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (pair_in),
    .pop_i   (pop),
    .data_o  (pair_out),
    .count_o (fifo_cnt)
  );

  ljpf_back #(
    .FRAC_BITS (FRAC_BITS),
    .SUM_WIDTH (SUM_WIDTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .avail_i     (fifo_cnt != 2'd0),
    .pair_i      (pair_out),
    .pop_o       (pop),
    .cut_i       (cut_q),
    .min_i       (min_q),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .accel_x_o   (accel_x),
    .accel_y_o   (accel_y),
    .accel_z_o   (accel_z),
    .saturated_o (m_axis_tuser)
  );

  assign m_axis_tdata = OutDataW'({accel_z, accel_y, accel_x});

`include "lj_pair_force_accumulator_core_assert.svh"

  `LJPF_ASSERT_ALL(a_reset_quiet, !rst_ni |-> !m_axis_tvalid)
  `LJPF_ASSERT_CLK(a_full_stalls, (fifo_cnt == 2'(FifoDepth)) |-> !s_axis_tready)
  `LJPF_ASSERT_CLK(a_push_lands, (push && !pop) |=> (fifo_cnt != 2'd0))
  `LJPF_ASSERT_CLK(a_no_pop_empty, pop |-> (fifo_cnt != 2'd0))

endmodule

// ===== src/ljpf_front.sv =====
// ----------------------------------------------------------------------------
// Pair front end
// Forms the nearest periodic image of each pair and flags pairs out of range.
// ----------------------------------------------------------------------------
module ljpf_front (
  input  logic [5:0][ljpf_pkg::CoordWidth-1:0] pos_i,
  input  logic                                 last_i,
  input  logic [ljpf_pkg::CfgWidth-1:0]        box_i,
  input  logic [ljpf_pkg::CfgWidth-1:0]        cut_i,
  output ljpf_pkg::pair_t                      pair_o
);
  import ljpf_pkg::*;

  logic signed [32:0] diff [3];
  logic signed [33:0] img  [3];
  logic [33:0]        imag [3];
  logic [2:0]         far;

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      diff[a] = 33'($signed(pos_i[3 + a])) - 33'($signed(pos_i[a]));
      img[a]  = nearest_image(diff[a], box_i);
      imag[a] = mag34(img[a]);
      far[a]  = imag[a] > {3'b000, cut_i};
      pair_o.mag[a] = imag[a][31:0];
      pair_o.pos[a] = !img[a][33] && (img[a] != '0);
    end
    pair_o.skip = |far;
    pair_o.last = last_i;
  end

endmodule

// ===== src/ljpf_fifo.sv =====
// ----------------------------------------------------------------------------
// Pair queue
// Two-entry queue that decouples the front end from the force sequencer.
// ----------------------------------------------------------------------------
module ljpf_fifo (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  ljpf_pkg::pair_t data_i,
  input  logic            pop_i,
  output ljpf_pkg::pair_t data_o,
  output logic [1:0]      count_o
);
  import ljpf_pkg::*;

  pair_t      mem_q [FifoDepth];
  logic       wr_q, wr_d;
  logic       rd_q, rd_d;
  logic [1:0] cnt_q, cnt_d;

  always_comb begin
    wr_d  = push_i ? !wr_q : wr_q;
    rd_d  = pop_i ? !rd_q : rd_q;
    cnt_d = cnt_q + 2'(push_i) - 2'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= data_i;
    end
  end

  assign data_o  = mem_q[rd_q];
  assign count_o = cnt_q;

endmodule

// ===== src/ljpf_back.sv =====
// ----------------------------------------------------------------------------
// Force sequencer
// Range test, reciprocal, power chain and saturating accumulation of a pair.
// ----------------------------------------------------------------------------
module ljpf_back #(
  parameter int FRAC_BITS = ljpf_pkg::FracBitsDef,
  parameter int SUM_WIDTH = ljpf_pkg::SumWidthDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          avail_i,
  input  ljpf_pkg::pair_t               pair_i,
  output logic                          pop_o,
  input  logic [ljpf_pkg::CfgWidth-1:0] cut_i,
  input  logic [ljpf_pkg::CfgWidth-1:0] min_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [SUM_WIDTH-1:0]          accel_x_o,
  output logic [SUM_WIDTH-1:0]          accel_y_o,
  output logic [SUM_WIDTH-1:0]          accel_z_o,
  output logic                          saturated_o
);
  import ljpf_pkg::*;

  localparam int DivTop  = 2 * FRAC_BITS + 32;
  localparam int DivIdxW = $clog2(DivTop + 1);

  localparam logic [2:0] PIdle = 3'd0;
  localparam logic [2:0] PRsq  = 3'd1;
  localparam logic [2:0] PChk  = 3'd2;
  localparam logic [2:0] PDiv  = 3'd3;
  localparam logic [2:0] PMul  = 3'd4;
  localparam logic [2:0] PTg   = 3'd5;
  localparam logic [2:0] PAcc  = 3'd6;
  localparam logic [2:0] PFin  = 3'd7;

  logic [2:0]  phase_q, phase_d;
  logic [2:0]  sub_q, sub_d;
  logic [2:0]  op_q, op_d;
  logic [DivIdxW-1:0] idx_q, idx_d;

  logic [2:0][31:0] mag_q, mag_d;
  logic [2:0]       pos_q, pos_d;
  logic             last_q, last_d;
  logic [63:0] r2_q, r2_d, cut2_q, cut2_d, mn2_q, mn2_d;
  logic [63:0] rem_q, rem_d, quo_q, quo_d;
  logic        ovf_q, ovf_d;
  logic [63:0] s_q, s_d, s2_q, s2_d, s3_q, s3_d, s4_q, s4_d;
  logic [63:0] acc_q, acc_d, g_q, g_d, pq_q, pq_d;
  logic        gneg_q, gneg_d;

  logic [SUM_WIDTH-1:0] sum_q [3];
  logic [SUM_WIDTH-1:0] sum_d [3];
  logic                 clip_q, clip_d;
  logic                 ov_q, ov_d;
  logic [SUM_WIDTH-1:0] ox_q, ox_d, oy_q, oy_d, oz_q, oz_d;
  logic                 osat_q, osat_d;

  logic [63:0] opa, opb;
  logic [31:0] ma, mb;
  logic [64:0] addw;
  logic [63:0] addend;
  logic [63:0] remn;
  logic [63:0] two7, tmag;
  logic [1:0]  axis;
  logic signed [65:0] se, me, res, hi, lo;

  always_comb begin
    axis = op_q[1:0];
    opa  = s_q;
    opb  = s_q;
    case (op_q)
      3'd0: begin opa = s_q;  opb = s_q;  end
      3'd1: begin opa = s2_q; opb = s_q;  end
      3'd2: begin opa = s2_q; opb = s2_q; end
      3'd3: begin opa = s4_q; opb = s3_q; end
      default: begin opa = g_q; opb = {32'd0, mag_q[axis]}; end
    endcase
    if (phase_q == PRsq) begin
      ma = (sub_q == 3'd3) ? {1'b0, cut_i} :
           (sub_q == 3'd4) ? {1'b0, min_i} : mag_q[sub_q[1:0]];
      mb = ma;
    end else begin
      ma = sub_q[1] ? opa[31:0] : opa[63:32];
      mb = sub_q[0] ? opb[31:0] : opb[63:32];
    end
    pq_d = 64'(ma) * 64'(mb);
  end

  always_comb begin
    phase_d = phase_q;
    sub_d   = sub_q;
    op_d    = op_q;
    idx_d   = idx_q;
    mag_d   = mag_q;
    pos_d   = pos_q;
    last_d  = last_q;
    r2_d    = r2_q;
    cut2_d  = cut2_q;
    mn2_d   = mn2_q;
    rem_d   = rem_q;
    quo_d   = quo_q;
    ovf_d   = ovf_q;
    s_d     = s_q;
    s2_d    = s2_q;
    s3_d    = s3_q;
    s4_d    = s4_q;
    acc_d   = acc_q;
    g_d     = g_q;
    gneg_d  = gneg_q;
    sum_d   = sum_q;
    clip_d  = clip_q;
    ov_d    = ov_q && !out_ready_i;
    ox_d    = ox_q;
    oy_d    = oy_q;
    oz_d    = oz_q;
    osat_d  = osat_q;
    pop_o   = 1'b0;
    addend  = (sub_q == 3'd4) ? {32'd0, pq_q[63:32]} : pq_q;
    addw    = {1'b0, acc_q} + {1'b0, addend};
    remn    = {rem_q[62:0], (idx_q == DivIdxW'(DivTop))};
    two7    = acc_q[63] ? SatMax : {acc_q[62:0], 1'b0};
    tmag    = (two7 >= s4_q) ? (two7 - s4_q) : (s4_q - two7);
    se      = 66'($signed(sum_q[axis]));
    me      = $signed({2'b00, acc_q});
    res     = (gneg_q ^ pos_q[axis]) ? (se - me) : (se + me);
    hi      = (66'sd1 <<< (SUM_WIDTH - 1)) - 66'sd1;
    lo      = -hi - 66'sd1;

    case (phase_q)
      PIdle: begin
        if (avail_i) begin
          pop_o  = 1'b1;
          mag_d  = pair_i.mag;
          pos_d  = pair_i.pos;
          last_d = pair_i.last;
          r2_d   = '0;
          sub_d  = 3'd0;
          phase_d = pair_i.skip ? PFin : PRsq;
        end
      end
      PRsq: begin
        if (sub_q != 3'd0) begin
          if (sub_q <= 3'd3) r2_d = r2_q + pq_q;
          else if (sub_q == 3'd4) cut2_d = pq_q;
          else mn2_d = pq_q;
        end
        sub_d = sub_q + 3'd1;
        if (sub_q == 3'd5) phase_d = PChk;
      end
      PChk: begin
        rem_d = '0;
        quo_d = '0;
        ovf_d = 1'b0;
        idx_d = DivIdxW'(DivTop);
        phase_d = ((r2_q > cut2_q) || (r2_q <= mn2_q)) ? PFin : PDiv;
      end
      PDiv: begin
        rem_d = remn;
        if (remn >= r2_q) begin
          rem_d = remn - r2_q;
          if (32'(idx_q) >= 32'd64) ovf_d = 1'b1;
          else quo_d[idx_q[5:0]] = 1'b1;
        end
        idx_d = idx_q - DivIdxW'(1);
        if (idx_q == '0) begin
          s_d = ovf_d ? SatMax : quo_d;
          op_d = 3'd0;
          sub_d = 3'd0;
          phase_d = PMul;
        end
      end
      PMul: begin
        case (sub_q)
          3'd0: acc_d = acc_q;
          3'd1: acc_d = (pq_q[63:32] != '0) ? SatMax : {pq_q[31:0], 32'd0};
          default: acc_d = addw[64] ? SatMax : addw[63:0];
        endcase
        sub_d = sub_q + 3'd1;
        if (sub_q == 3'd4) begin
          sub_d = 3'd0;
          case (op_q)
            3'd0: begin s2_d = acc_d; op_d = 3'd1; end
            3'd1: begin s3_d = acc_d; op_d = 3'd2; end
            3'd2: begin s4_d = acc_d; op_d = 3'd3; end
            3'd3: phase_d = PTg;
            default: phase_d = PAcc;
          endcase
        end
      end
      PTg: begin
        gneg_d = two7 < s4_q;
        g_d = (tmag > GainLim) ? SatMax : ({tmag[59:0], 4'd0} + {tmag[60:0], 3'd0});
        op_d = 3'd4;
        sub_d = 3'd0;
        phase_d = PMul;
      end
      PAcc: begin
        if (res > hi) begin
          sum_d[axis] = hi[SUM_WIDTH-1:0];
          clip_d = 1'b1;
        end else if (res < lo) begin
          sum_d[axis] = lo[SUM_WIDTH-1:0];
          clip_d = 1'b1;
        end else begin
          sum_d[axis] = res[SUM_WIDTH-1:0];
        end
        op_d = op_q + 3'd1;
        phase_d = (op_q == 3'd6) ? PFin : PMul;
      end
      PFin: begin
        if (!last_q) begin
          phase_d = PIdle;
        end else if (!ov_q || out_ready_i) begin
          ov_d   = 1'b1;
          ox_d   = sum_q[0];
          oy_d   = sum_q[1];
          oz_d   = sum_q[2];
          osat_d = clip_q;
          for (int a = 0; a < 3; a++) sum_d[a] = '0;
          clip_d = 1'b0;
          phase_d = PIdle;
        end
      end
      default: phase_d = PIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PIdle;
      sub_q   <= 3'd0;
      op_q    <= 3'd0;
      idx_q   <= '0;
      ov_q    <= 1'b0;
      clip_q  <= 1'b0;
      for (int a = 0; a < 3; a++) sum_q[a] <= '0;
    end else begin
      phase_q <= phase_d;
      sub_q   <= sub_d;
      op_q    <= op_d;
      idx_q   <= idx_d;
      ov_q    <= ov_d;
      clip_q  <= clip_d;
      sum_q   <= sum_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mag_q  <= mag_d;
    pos_q  <= pos_d;
    last_q <= last_d;
    r2_q   <= r2_d;
    cut2_q <= cut2_d;
    mn2_q  <= mn2_d;
    rem_q  <= rem_d;
    quo_q  <= quo_d;
    ovf_q  <= ovf_d;
    s_q    <= s_d;
    s2_q   <= s2_d;
    s3_q   <= s3_d;
    s4_q   <= s4_d;
    acc_q  <= acc_d;
    g_q    <= g_d;
    gneg_q <= gneg_d;
    pq_q   <= pq_d;
    ox_q   <= ox_d;
    oy_q   <= oy_d;
    oz_q   <= oz_d;
    osat_q <= osat_d;
  end

  assign out_valid_o = ov_q;
  assign accel_x_o   = ox_q;
  assign accel_y_o   = oy_q;
  assign accel_z_o   = oz_q;
  assign saturated_o = osat_q;

endmodule

// ===== verif/lj_pair_force_accumulator_core_test.sv =====
// ----------------------------------------------------------------------------
// Pair force accumulator testbench
// Streams particle pairs through the block under several register settings,
// predicts each particle's summed Lennard-Jones acceleration and saturation
// flag with a bit-exact fixed-point model, and checks every output
// transaction against it with random input idling and output back-pressure.
// ----------------------------------------------------------------------------
module lj_pair_force_accumulator_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  import ljpf_pkg::*;

  localparam int  SumW      = SumWidthDef;
  localparam int  CycleLimit = 1500000;
  localparam int  DrainWait = 600;

  typedef struct packed {
    logic [5:0][31:0] coord;
    logic             last;
  } pair_item_t;

  typedef struct packed {
    logic [SumW-1:0] ax;
    logic [SumW-1:0] ay;
    logic [SumW-1:0] az;
    logic            sat;
  } accel_t;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b1;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [191:0] s_axis_tdata = '0;
  logic         s_axis_tlast = 1'b0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [((3*SumW+7)/8)*8-1:0] m_axis_tdata;
  logic         m_axis_tuser;
  logic         psel = 1'b0;
  logic         penable = 1'b0;
  logic         pwrite = 1'b0;
  logic [3:0]   paddr = '0;
  logic [31:0]  pwdata = '0;
  logic [31:0]  prdata;
  logic         pready;

  lj_pair_force_accumulator_core u_top (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tlast,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  pair_item_t  pending_pairs[$];
  accel_t      expected_accels[$];
  logic [63:0] box_len = 64'(BoxReset);
  logic [63:0] cut_dist = 64'(CutReset);
  logic [63:0] min_dist = 64'(MinReset);
  longint      acc_x = 0;
  longint      acc_y = 0;
  longint      acc_z = 0;
  bit          clip_flag = 1'b0;
  int          cycle_cnt = 0;
  int          fail_cnt = 0;
  int          pairs_sent = 0;
  int          accels_seen = 0;
  int          sat_seen = 0;
  bit          offer_taken = 1'b0;
  bit          stall_req = 1'b0;
  int          stall_left = 0;
  wire         calm = ((cycle_cnt / 5000) % 4) == 1;

  function automatic logic [63:0] mag_of(input logic signed [63:0] v);
    return v < 0 ? -v : v;
  endfunction

  function automatic logic [63:0] qmul(input logic [63:0] a, input logic [63:0] b);
    logic [127:0] p;
    p = 128'(a);
    p = (p * b) >> 32;
    return (p[127:64] != 0) ? '1 : p[63:0];
  endfunction

  function automatic logic signed [63:0] wrap_axis(input logic signed [63:0] d);
    logic signed [63:0] len;
    logic signed [63:0] best;
    len = box_len;
    best = d - len;
    if (mag_of(d) < mag_of(best)) best = d;
    if (mag_of(d + len) < mag_of(best)) best = d + len;
    return best;
  endfunction

  task automatic add_term(inout longint acc, input bit neg, input logic [63:0] m);
    logic signed [127:0] v;
    logic signed [127:0] mm;
    logic signed [127:0] hi;
    hi = (128'sd1 <<< (SumW - 1)) - 1;
    v = 128'(acc);
    mm = {64'd0, m};
    v = neg ? v - mm : v + mm;
    if (v > hi) begin
      acc = longint'(hi);
      clip_flag = 1'b1;
    end else if (v < -hi - 1) begin
      acc = longint'(-hi - 1);
      clip_flag = 1'b1;
    end else begin
      acc = longint'(v);
    end
  endtask

  task automatic apply_pair(input pair_item_t it);
    logic signed [63:0] img[3];
    logic [63:0]  r2;
    logic [127:0] q;
    logic [63:0]  s, s2, s3, s4, s7, two7, tmag, gmag;
    bit           gneg;
    bit           in_range;
    accel_t       res;
    in_range = 1'b1;
    r2 = 0;
    for (int a = 0; a < 3; a++) begin
      img[a] = wrap_axis(longint'($signed(it.coord[3+a])) - longint'($signed(it.coord[a])));
      if (mag_of(img[a]) > cut_dist) in_range = 1'b0;
    end
    if (in_range) begin
      for (int a = 0; a < 3; a++) r2 += mag_of(img[a]) * mag_of(img[a]);
      if (r2 > cut_dist * cut_dist || r2 <= min_dist * min_dist) in_range = 1'b0;
    end
    if (in_range) begin
      q = (128'd1 << 64) / r2;
      s = (q[127:64] != 0) ? '1 : q[63:0];
      s2 = qmul(s, s);
      s3 = qmul(s2, s);
      s4 = qmul(s2, s2);
      s7 = qmul(s4, s3);
      two7 = s7[63] ? '1 : s7 << 1;
      gneg = two7 < s4;
      tmag = gneg ? s4 - two7 : two7 - s4;
      gmag = (tmag > 64'hFFFF_FFFF_FFFF_FFFF / 24) ? '1 : tmag * 24;
      add_term(acc_x, gneg != (img[0] > 0), qmul(gmag, mag_of(img[0])));
      add_term(acc_y, gneg != (img[1] > 0), qmul(gmag, mag_of(img[1])));
      add_term(acc_z, gneg != (img[2] > 0), qmul(gmag, mag_of(img[2])));
    end
    if (it.last) begin
      res.ax = acc_x[SumW-1:0];
      res.ay = acc_y[SumW-1:0];
      res.az = acc_z[SumW-1:0];
      res.sat = clip_flag;
      expected_accels.push_back(res);
      acc_x = 0;
      acc_y = 0;
      acc_z = 0;
      clip_flag = 1'b0;
    end
  endtask

  // Input side: prediction at acceptance, offers changed at the falling edge.
  always @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      apply_pair(pending_pairs.pop_front());
      pairs_sent++;
      offer_taken = 1'b1;
    end
  end

  always @(negedge clk_i) begin
    if (!s_axis_tvalid || offer_taken) begin
      if (pending_pairs.size() > 0 && (calm || $urandom_range(99) >= 32)) begin
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= pending_pairs[0].coord;
        s_axis_tlast  <= pending_pairs[0].last;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
    offer_taken = 1'b0;
  end

  // Output side: ready with random idling and one long hold-off.
  always @(negedge clk_i) begin
    if (stall_req) begin
      stall_left = 3000;
      stall_req = 1'b0;
    end
    if (stall_left > 0) begin
      stall_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= calm || $urandom_range(99) >= 32;
    end
  end

  always @(posedge clk_i) begin
    accel_t exp_r;
    cycle_cnt++;
    if (m_axis_tvalid && m_axis_tready) begin
      accels_seen++;
      if (m_axis_tuser) sat_seen++;
      if (expected_accels.size() == 0) begin
        $error("unexpected output transaction");
        fail_cnt++;
      end else begin
        exp_r = expected_accels.pop_front();
        if (m_axis_tdata[SumW-1:0] !== exp_r.ax) begin
          $error("accel_x expected %h got %h", exp_r.ax, m_axis_tdata[SumW-1:0]);
          fail_cnt++;
        end
        if (m_axis_tdata[2*SumW-1:SumW] !== exp_r.ay) begin
          $error("accel_y expected %h got %h", exp_r.ay, m_axis_tdata[2*SumW-1:SumW]);
          fail_cnt++;
        end
        if (m_axis_tdata[3*SumW-1:2*SumW] !== exp_r.az) begin
          $error("accel_z expected %h got %h", exp_r.az, m_axis_tdata[3*SumW-1:2*SumW]);
          fail_cnt++;
        end
        if (m_axis_tuser !== exp_r.sat) begin
          $error("saturated expected %b got %b", exp_r.sat, m_axis_tuser);
          fail_cnt++;
        end
      end
    end
    if (cycle_cnt > CycleLimit) begin
      $display("Timeout after %0d cycles", cycle_cnt);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  task automatic write_reg(input logic [1:0] idx, input logic [30:0] val);
    @(negedge clk_i);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= {idx, 2'b00};
    pwdata <= {1'b0, val};
    @(negedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      RegBox: box_len = 64'(val);
      RegCut: cut_dist = 64'(val);
      default: min_dist = 64'(val);
    endcase
  endtask

  task automatic set_window(input logic [30:0] b, input logic [30:0] c, input logic [30:0] m);
    write_reg(RegBox, b);
    write_reg(RegCut, c);
    write_reg(RegMin, m);
  endtask

  task automatic push_pair(input logic [31:0] sx, sy, sz, ox, oy, oz, input bit last);
    pair_item_t it;
    it.coord = {oz, oy, ox, sz, sy, sx};
    it.last = last;
    pending_pairs.push_back(it);
  endtask

  function automatic logic [31:0] near_coord(input logic [31:0] base);
    longint c;
    longint off;
    c = (cut_dist > 64'h4000_0000) ? 64'h4000_0000 : cut_dist;
    off = longint'($urandom_range(32'(2 * c))) - c;
    case ($urandom_range(9))
      0: off += box_len;
      1: off -= box_len;
      default: ;
    endcase
    return base + 32'(off);
  endfunction

  task automatic random_pairs(input int n);
    logic [31:0] s[3];
    logic [31:0] o[3];
    int          left;
    int          kind;
    left = 0;
    for (int k = 0; k < n; k++) begin
      if (left == 0) begin
        left = $urandom_range(1, 8);
        for (int a = 0; a < 3; a++) s[a] = $urandom();
      end
      kind = $urandom_range(99);
      for (int a = 0; a < 3; a++) begin
        if (kind < 75) o[a] = near_coord(s[a]);
        else if (kind < 90) o[a] = $urandom();
        else o[a] = $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      end
      if (kind >= 95) s[0] = ~o[0];
      left--;
      push_pair(s[0], s[1], s[2], o[0], o[1], o[2], left == 0);
    end
  endtask

  task automatic drain();
    while (pending_pairs.size() != 0 || expected_accels.size() != 0) @(negedge clk_i);
    repeat (DrainWait) @(negedge clk_i);
  endtask

  initial begin
    rst_ni <= 1'b0;
    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;
    repeat (3) @(negedge clk_i);

    // Directed pairs under the reset window.
    push_pair(32'h8000_0000, 32'h7FFF_FFFF, 0, 32'h7FFF_FFFF, 32'h8000_0000, 0, 1);
    push_pair(32'd1000, 32'd1000, 32'd1000, 32'd1000, 32'd1000, 32'd1000, 1);
    push_pair(0, 0, 0, 32'd100000, 0, 0, 0);
    push_pair(0, 0, 0, 0, 32'hFFFE_7960, 0, 0);
    push_pair(0, 0, 0, 0, 0, 32'd72370, 0);
    push_pair(0, 0, 0, 32'd183914, 0, 0, 1);
    push_pair(0, 0, 0, 32'd183915, 0, 0, 0);
    push_pair(0, 0, 0, 32'd72371, 0, 0, 0);
    push_pair(0, 0, 0, 32'd3329229, 32'd100000, 0, 1);
    push_pair(32'd6600000, 0, 0, 32'hFFFF_0000, 32'd80000, 32'd60000, 1);
    push_pair(32'd5, 32'd7, 32'd9, 32'd95000, 32'hFFFE_D000, 32'd9, 1);
    drain();

    set_window(31'd3329228, 31'd183914, 31'd72370);
    push_pair(0, 0, 0, 32'd1664614, 0, 0, 1);
    random_pairs(200);
    drain();

    set_window(31'h7FFF_FFFF, 31'h7FFF_FFFF, 31'd0);
    push_pair(0, 0, 0, 0, 0, 0, 0);
    push_pair(0, 0, 0, 32'd1, 0, 0, 0);
    push_pair(0, 0, 0, 32'd65536, 32'd2, 0, 1);
    random_pairs(100);
    drain();

    set_window(31'd0, 31'd200000, 31'd0);
    random_pairs(100);
    drain();

    set_window(31'd6658458, 31'd50000, 31'd100000);
    random_pairs(60);
    drain();

    set_window(31'd6658458, 31'h7FFF_FFFF, 31'h7FFF_FFFF);
    random_pairs(40);
    drain();

    set_window(BoxReset, CutReset, MinReset);
    stall_req = 1'b1;
    random_pairs(600);
    drain();

    set_window(31'($urandom_range(32'd400000, 32'd20000000)), 31'd250000, 31'd40000);
    random_pairs(300);
    drain();

    $display("Sent %0d pairs over eight register windows and checked %0d sums.",
             pairs_sent, accels_seen);
    $display("%0d sums came back saturated; %0d mismatches.", sat_seen, fail_cnt);
    if (fail_cnt == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
